// ----- design/int_floor_mod_div_unit_macros.svh -----
// Assertion macros for the integer floor/modulo divide unit.
// Used by the checker; depends on nothing else.
`ifndef INT_FLOOR_MOD_DIV_UNIT_MACROS_SVH
`define INT_FLOOR_MOD_DIV_UNIT_MACROS_SVH

`define IFMD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ifmd assertion failed");

`define IFMD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `IFMD_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ----- design/ifmd_pkg.sv -----
// Package for the integer floor/modulo divide unit: widths, codes and
// the types passed along the divider chain. Depends on nothing.
`default_nettype none

package ifmd_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CFG_WIDTH  = DATA_WIDTH;
  localparam int unsigned IDX_WIDTH  = 2;
  localparam int unsigned LATENCY    = DATA_WIDTH + 2;

  typedef enum logic [1:0] {
    OP_FLOOR_MOD  = 2'd0,
    OP_TRUNC_MOD  = 2'd1,
    OP_FLOOR_DIV  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BC_NONE     = 2'd0,
    BC_DIVIDEND = 2'd1,
    BC_DIVISOR  = 2'd2
  } bcast_e;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_OPERATION = 2'd0,
    REG_BCAST     = 2'd1,
    REG_SCALAR    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                  a_neg;
    logic                  b_neg;
    logic                  b_zero;
    logic                  last;
    logic [DATA_WIDTH-1:0] b;
  } side_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] aq;
    logic [DATA_WIDTH-1:0] bm;
    side_t                 side;
  } work_t;

endpackage

`default_nettype wire

// ----- design/int_floor_mod_div_unit.sv -----
// Top level of the integer floor/modulo divide unit: configuration
// registers and the divider chain. Depends on ifmd_pkg, ifmd_pre,
// ifmd_cell and ifmd_post.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//   operands | start_i, busy_o    | dividend_i, divisor_i, last_in_i
//   result   | valid_o (strobe)   | value_o, zero_divisor_o, last_out_o
//
// One transaction is taken every cycle; busy_o stays low.
// Stages in order: an operand stage, one cell per quotient bit in the
// restoring chain, and a result stage.
// Reset clears the configuration and all valid flags in the chain.
// The result side cannot stall; each result shows for one cycle.
`default_nettype none

module int_floor_mod_div_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifmd_pkg::IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [ifmd_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] divisor_i,
  input  logic                            last_in_i,
  output logic                            valid_o,
  output logic [ifmd_pkg::DATA_WIDTH-1:0] value_o,
  output logic                            zero_divisor_o,
  output logic                            last_out_o
);

  localparam int unsigned W = ifmd_pkg::DATA_WIDTH;

  logic [1:0]      op_q, bcast_q;
  logic [W-1:0]    scalar_q;
  logic            accept;
  logic            valid_s [W+1];
  ifmd_pkg::work_t data_s  [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= 2'd0;
      bcast_q  <= 2'd0;
      scalar_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ifmd_pkg::REG_OPERATION: op_q     <= cfg_data_i[1:0];
        ifmd_pkg::REG_BCAST:     bcast_q  <= cfg_data_i[1:0];
        ifmd_pkg::REG_SCALAR:    scalar_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  ifmd_pre u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .last_i     (last_in_i),
    .bcast_i    (bcast_q),
    .scalar_i   (scalar_q),
    .valid_o    (valid_s[0]),
    .data_o     (data_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    ifmd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .data_i  (data_s[i]),
      .valid_o (valid_s[i+1]),
      .data_o  (data_s[i+1])
    );
  end

  ifmd_post u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_s[W]),
    .data_i         (data_s[W]),
    .op_i           (op_q),
    .valid_o        (valid_o),
    .value_o        (value_o),
    .zero_divisor_o (zero_divisor_o),
    .last_out_o     (last_out_o)
  );

endmodule

`default_nettype wire

// ----- design/ifmd_pre.sv -----
// Operand selection and sign/magnitude split at the head of the chain.
// Depends on ifmd_pkg.
`default_nettype none

module ifmd_pre (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] divisor_i,
  input  logic                            last_i,
  input  logic [1:0]                      bcast_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] scalar_i,
  output logic                            valid_o,
  output ifmd_pkg::work_t                 data_o
);

  logic [ifmd_pkg::DATA_WIDTH-1:0] a, b;
  logic                            a_neg, b_neg;
  logic                            valid_q;
  ifmd_pkg::work_t                 data_d, data_q;

  always_comb begin
    a = dividend_i;
    b = divisor_i;
    case (bcast_i)
      ifmd_pkg::BC_DIVIDEND: a = scalar_i;
      ifmd_pkg::BC_DIVISOR:  b = scalar_i;
      default: ;
    endcase
    a_neg = a[ifmd_pkg::DATA_WIDTH-1];
    b_neg = b[ifmd_pkg::DATA_WIDTH-1];
    data_d.rem         = '0;
    data_d.aq          = a_neg ? -a : a;
    data_d.bm          = b_neg ? -b : b;
    data_d.side.a_neg  = a_neg;
    data_d.side.b_neg  = b_neg;
    data_d.side.b_zero = (b == '0);
    data_d.side.last   = last_i;
    data_d.side.b      = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- design/ifmd_cell.sv -----
// One restoring-division cell: produces one quotient bit and hands the
// partial remainder on. Depends on ifmd_pkg.
`default_nettype none

module ifmd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ifmd_pkg::work_t data_i,
  output logic            valid_o,
  output ifmd_pkg::work_t data_o
);

  localparam int unsigned W = ifmd_pkg::DATA_WIDTH;

  logic [W-1:0]    shifted;
  logic [W:0]      trial;
  logic            fits;
  logic            valid_q;
  ifmd_pkg::work_t data_d, data_q;

  always_comb begin
    shifted = {data_i.rem[W-2:0], data_i.aq[W-1]};
    trial   = {1'b0, shifted} - {1'b0, data_i.bm};
    fits    = !trial[W];
    data_d      = data_i;
    data_d.rem  = fits ? trial[W-1:0] : shifted;
    data_d.aq   = {data_i.aq[W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- design/ifmd_post.sv -----
// Sign correction and result selection at the tail of the chain.
// Depends on ifmd_pkg.
`default_nettype none

module ifmd_post (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  ifmd_pkg::work_t                 data_i,
  input  logic [1:0]                      op_i,
  output logic                            valid_o,
  output logic [ifmd_pkg::DATA_WIDTH-1:0] value_o,
  output logic                            zero_divisor_o,
  output logic                            last_out_o
);

  logic [ifmd_pkg::DATA_WIDTH-1:0] q, r, res;
  logic                            diff, adjust;
  logic                            valid_q, zero_q, last_q;
  logic [ifmd_pkg::DATA_WIDTH-1:0] value_q;

  always_comb begin
    diff   = data_i.side.a_neg ^ data_i.side.b_neg;
    q      = diff ? -data_i.aq : data_i.aq;
    r      = data_i.side.a_neg ? -data_i.rem : data_i.rem;
    adjust = (data_i.rem != '0) && diff;
    case (op_i)
      ifmd_pkg::OP_FLOOR_MOD: res = adjust ? r + data_i.side.b : r;
      ifmd_pkg::OP_TRUNC_MOD: res = r;
      ifmd_pkg::OP_FLOOR_DIV: res = adjust ? q - 1'b1 : q;
      default:                res = '0;
    endcase
    if (data_i.side.b_zero) begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= res;
    zero_q  <= data_i.side.b_zero;
    last_q  <= data_i.side.last;
  end

  assign valid_o        = valid_q;
  assign value_o        = value_q;
  assign zero_divisor_o = zero_q;
  assign last_out_o     = last_q;

endmodule

`default_nettype wire

// ----- design/ifmd_checker.sv -----
// Port-level checks for the integer floor/modulo divide unit, bound to
// the top level. Depends on ifmd_pkg and the macros header.
`default_nettype none
`include "int_floor_mod_div_unit_macros.svh"

module ifmd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            valid_o,
  input logic [ifmd_pkg::DATA_WIDTH-1:0] value_o,
  input logic                            zero_divisor_o
);

  `IFMD_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o)
  `IFMD_ASSERT(a_result_follows, clk_i, rst_ni, (start_i && !busy_o) |-> ##(ifmd_pkg::LATENCY) valid_o)
  `IFMD_ASSERT(a_result_caused, clk_i, rst_ni, valid_o |-> $past(start_i && !busy_o, ifmd_pkg::LATENCY))
  `IFMD_ASSERT(a_zero_value, clk_i, rst_ni, (valid_o && zero_divisor_o) |-> (value_o == '0))

endmodule

bind int_floor_mod_div_unit ifmd_checker u_ifmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .value_o        (value_o),
  .zero_divisor_o (zero_divisor_o)
);

`default_nettype wire

// ----- tb/sv/ifmd_result_checker.sv -----
// Result checker for the integer floor/modulo divide unit: tracks the register
// writes, predicts one result per accepted operand pair and compares in order.
// Depends on ifmd_pkg.
`timescale 1ns / 100ps

module ifmd_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifmd_pkg::IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [ifmd_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] divisor_i,
  input  logic                            last_in_i,
  input  logic                            valid_i,
  input  logic [ifmd_pkg::DATA_WIDTH-1:0] value_i,
  input  logic                            zero_divisor_i,
  input  logic                            last_out_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import ifmd_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  zero_divisor;
    logic                  last;
  } quotient_res_t;

  logic [1:0]            op_sel;
  logic [1:0]            bcast_sel;
  logic [DATA_WIDTH-1:0] scalar_val;
  quotient_res_t         awaited_results[$];
  int                    mismatches = 0;
  int                    backlog = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  function automatic quotient_res_t floor_divide(input logic [DATA_WIDTH-1:0] dividend,
                                                 input logic [DATA_WIDTH-1:0] divisor,
                                                 input logic                  last);
    logic [DATA_WIDTH-1:0] a, b, a_mag, b_mag, q_mag, r_mag, quot, rem;
    logic                  a_neg, b_neg, adjust;
    quotient_res_t         res;
    a = dividend;
    b = divisor;
    if (bcast_sel == BC_DIVIDEND) begin
      a = scalar_val;
    end else if (bcast_sel == BC_DIVISOR) begin
      b = scalar_val;
    end
    res.value        = '0;
    res.zero_divisor = (b == '0);
    res.last         = last;
    if (!res.zero_divisor) begin
      a_neg  = a[DATA_WIDTH-1];
      b_neg  = b[DATA_WIDTH-1];
      a_mag  = a_neg ? -a : a;
      b_mag  = b_neg ? -b : b;
      q_mag  = a_mag / b_mag;
      r_mag  = a_mag % b_mag;
      quot   = (a_neg != b_neg) ? -q_mag : q_mag;
      rem    = a_neg ? -r_mag : r_mag;
      adjust = (r_mag != '0) && (a_neg != b_neg);
      case (op_sel)
        OP_FLOOR_MOD: res.value = adjust ? rem + b : rem;
        OP_TRUNC_MOD: res.value = rem;
        OP_FLOOR_DIV: res.value = adjust ? quot - 1'b1 : quot;
        default:      res.value = '0;
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                 input logic [DATA_WIDTH-1:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quotient_res_t want;
    if (!rst_ni) begin
      op_sel     <= OP_FLOOR_MOD;
      bcast_sel  <= BC_NONE;
      scalar_val <= '0;
      awaited_results.delete();
      backlog    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OPERATION: op_sel     <= cfg_data_i[1:0];
          REG_BCAST:     bcast_sel  <= cfg_data_i[1:0];
          REG_SCALAR:    scalar_val <= cfg_data_i[DATA_WIDTH-1:0];
          default: ;
        endcase
      end
      if (valid_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, value", value_i, '0);
        end else begin
          want = awaited_results.pop_front();
          if (value_i !== want.value)
            report_mismatch("value", value_i, want.value);
          if (zero_divisor_i !== want.zero_divisor)
            report_mismatch("zero_divisor", DATA_WIDTH'(zero_divisor_i),
                            DATA_WIDTH'(want.zero_divisor));
          if (last_out_i !== want.last)
            report_mismatch("last_out", DATA_WIDTH'(last_out_i), DATA_WIDTH'(want.last));
        end
      end
      if (start_i && !busy_i)
        awaited_results.push_back(floor_divide(dividend_i, divisor_i, last_in_i));
      backlog <= awaited_results.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the integer floor/modulo divide unit: clock, reset,
// register writes and operand stimulus, watchdog and verdict.
// Depends on ifmd_pkg, int_floor_mod_div_unit and ifmd_result_checker.
`timescale 1ns / 100ps

module tb;
  import ifmd_pkg::*;

  localparam int unsigned           W           = DATA_WIDTH;
  localparam logic [W-1:0]          MOST_NEG    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]          MOST_POS    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]          MINUS_ONE   = '1;
  localparam logic [1:0]            OP_RESERVED = 2'd3;
  localparam logic [1:0]            BC_RESERVED = 2'd3;
  localparam logic [IDX_WIDTH-1:0]  REG_NONE    = 2'd3;
  localparam int                    STALL_LIMIT = 2000;
  localparam int                    RAND_PHASES = 18;
  localparam int                    PHASE_ITEMS = 76;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [IDX_WIDTH-1:0] cfg_idx_i;
  logic [CFG_WIDTH-1:0] cfg_data_i;
  logic                 start_i;
  logic                 busy_o;
  logic [W-1:0]         dividend_i;
  logic [W-1:0]         divisor_i;
  logic                 last_in_i;
  logic                 valid_o;
  logic [W-1:0]         value_o;
  logic                 zero_divisor_o;
  logic                 last_out_o;
  int                   fail_count;
  int                   pending;
  int                   stall_cycles = 0;
  logic                 idling = 1'b1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int_floor_mod_div_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .busy_o, .dividend_i, .divisor_i, .last_in_i,
    .valid_o, .value_o, .zero_divisor_o, .last_out_o
  );

  ifmd_result_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i, .busy_i(busy_o), .dividend_i, .divisor_i, .last_in_i,
    .valid_i(valid_o), .value_i(value_o), .zero_divisor_i(zero_divisor_o),
    .last_out_i(last_out_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || cfg_we_i || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    int unsigned  sel;
    sel = $urandom_range(15);
    if (sel < 2) begin
      case ($urandom_range(4))
        0:       v = '0;
        1:       v = 1;
        2:       v = MINUS_ONE;
        3:       v = MOST_NEG;
        default: v = MOST_POS;
      endcase
    end else if (sel < 6) begin
      v = W'($urandom_range(40)) - W'(20);
    end else if (sel < 10) begin
      v = W'($urandom) >> $urandom_range(W-1);
      if ($urandom_range(1)) v = -v;
    end else begin
      v = W'($urandom);
    end
    return v;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b, input logic last);
    while (idling && $urandom_range(99) < 35) begin
      start_i    <= 1'b0;
      dividend_i <= W'($urandom);
      divisor_i  <= W'($urandom);
      last_in_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    start_i    <= 1'b1;
    dividend_i <= a;
    divisor_i  <= b;
    last_in_i  <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [1:0] op, input logic [1:0] bc,
                                input logic [W-1:0] scalar);
    logic [CFG_WIDTH-1:0] word;
    settle();
    word       = CFG_WIDTH'($urandom);
    word[1:0]  = op;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_OPERATION;
    cfg_data_i <= word;
    @(negedge clk_i);
    word       = CFG_WIDTH'($urandom);
    word[1:0]  = bc;
    cfg_idx_i  <= REG_BCAST;
    cfg_data_i <= word;
    @(negedge clk_i);
    cfg_idx_i  <= REG_SCALAR;
    cfg_data_i <= CFG_WIDTH'(scalar);
    @(negedge clk_i);
    // index with no register behind it: must change nothing
    cfg_idx_i  <= REG_NONE;
    cfg_data_i <= CFG_WIDTH'($urandom);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_pair(pick_operand(), pick_operand(), $urandom_range(7) == 0);
  endtask

  initial begin
    logic [W-1:0] dir_a[8];
    logic [W-1:0] dir_b[8];
    logic [1:0]   op, bc;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_OPERATION;
    cfg_data_i = '0;
    start_i    = 1'b0;
    dividend_i = '0;
    divisor_i  = '0;
    last_in_i  = 1'b0;
    dir_a = '{W'(7),  -W'(7), -W'(7), W'(6),  MOST_NEG,  MOST_NEG, MOST_POS, MOST_NEG};
    dir_b = '{-W'(2), W'(2),  -W'(2), -W'(3), MINUS_ONE, '0,       MOST_NEG, MOST_POS};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < 4; k++) begin
      apply_settings(2'(k), BC_NONE, '0);
      for (int i = 0; i < 8; i++) send_pair(dir_a[i], dir_b[i], 1'(i % 2));
    end

    apply_settings(OP_FLOOR_DIV, BC_DIVIDEND, MOST_NEG);
    run_random(40);
    apply_settings(OP_FLOOR_MOD, BC_DIVISOR, MINUS_ONE);
    run_random(40);
    apply_settings(OP_TRUNC_MOD, BC_DIVISOR, '0);
    run_random(40);
    apply_settings(OP_FLOOR_DIV, BC_DIVISOR, MOST_POS);
    run_random(40);
    apply_settings(OP_FLOOR_MOD, BC_DIVIDEND, MOST_POS);
    idling = 1'b0;
    run_random(PHASE_ITEMS);
    idling = 1'b1;
    apply_settings(OP_TRUNC_MOD, BC_RESERVED, pick_operand());
    run_random(40);
    apply_settings(OP_RESERVED, BC_DIVISOR, pick_operand());
    run_random(40);

    for (int p = 0; p < RAND_PHASES; p++) begin
      op = ($urandom_range(9) == 0) ? OP_RESERVED : 2'($urandom_range(2));
      bc = ($urandom_range(9) == 0) ? BC_RESERVED : 2'($urandom_range(2));
      apply_settings(op, bc, pick_operand());
      run_random(PHASE_ITEMS);
    end

    settle();
    repeat (LATENCY + 4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ifmd_pkg.sv
design/ifmd_pre.sv
design/ifmd_cell.sv
design/ifmd_post.sv
design/int_floor_mod_div_unit.sv
design/ifmd_checker.sv
tb/sv/ifmd_result_checker.sv
tb/sv/tb.sv
